[rtl/pket_pkg.sv]
// ----------------------------------------------------------------------------
// pket_pkg
// Shared types and constants of the per-key event throttle.
// ----------------------------------------------------------------------------
package pket_pkg;

   localparam int SLOTS_DEF    = 32;
   localparam int KEY_BITS_DEF = 32;

   localparam int KEY_W    = 32;
   localparam int KIND_W   = 2;
   localparam int TIME_W   = 32;
   localparam int THR_W    = 8;
   localparam int LIMIT_W  = 6;
   localparam int CSR_IDX_W = 1;
   localparam int CSR_DATA_W = 8;

   localparam logic [THR_W-1:0]   THROTTLE_RESET = THR_W'(2);
   localparam logic [LIMIT_W-1:0] LIMIT_RESET    = LIMIT_W'(20);

   localparam logic [KIND_W-1:0] KIND_CHANGED = 2'd0;
   localparam logic [KIND_W-1:0] KIND_CREATED = 2'd1;
   localparam logic [KIND_W-1:0] KIND_DELETED = 2'd2;

   localparam logic [CSR_IDX_W-1:0] CSR_THROTTLE = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_LIMIT    = 1'b1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DRAIN,
      ST_UPDATE,
      ST_RESP
   } pket_state_type;

   typedef struct packed {
      logic load;
      logic scan;
      logic commit;
      logic respond;
   } pket_cmd_type;

   typedef struct packed {
      logic in_changed;
      logic scan_last;
      logic rsp_free;
   } pket_sts_type;

endpackage

[rtl/pket_req_if.sv]
// ----------------------------------------------------------------------------
// pket_req_if
// Request channel: event key, kind, force flag and timestamp.
// ----------------------------------------------------------------------------
interface pket_req_if;
   logic                          valid;
   logic                          ready;
   logic [pket_pkg::KEY_W-1:0]    key_id;
   logic [pket_pkg::KIND_W-1:0]   event_kind;
   logic                          force_req;
   logic [pket_pkg::TIME_W-1:0]   now_seconds;

   modport source (output valid, key_id, event_kind, force_req, now_seconds, input ready);
   modport sink   (input valid, key_id, event_kind, force_req, now_seconds, output ready);
endinterface

[rtl/pket_rsp_if.sv]
// ----------------------------------------------------------------------------
// pket_rsp_if
// Response channel: emit decision, echoed kind and key.
// ----------------------------------------------------------------------------
interface pket_rsp_if;
   logic                          valid;
   logic                          ready;
   logic                          emit;
   logic [pket_pkg::KIND_W-1:0]   signal_kind;
   logic [pket_pkg::KEY_W-1:0]    out_key;

   modport source (output valid, emit, signal_kind, out_key, input ready);
   modport sink   (input valid, emit, signal_kind, out_key, output ready);
endinterface

[rtl/pket_ram.sv]
// ----------------------------------------------------------------------------
// pket_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module pket_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[rtl/pket_ctrl.sv]
// ----------------------------------------------------------------------------
// pket_ctrl
// Sequencer: accept, table scan, update, response.
// ----------------------------------------------------------------------------
module pket_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  pket_pkg::pket_sts_type sts,
   output pket_pkg::pket_cmd_type cmd
);

   pket_pkg::pket_state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         pket_pkg::ST_IDLE: begin
            if (req_valid) begin
               state_in = sts.in_changed ? pket_pkg::ST_SCAN : pket_pkg::ST_RESP;
            end
         end
         pket_pkg::ST_SCAN: begin
            if (sts.scan_last) begin
               state_in = pket_pkg::ST_DRAIN;
            end
         end
         pket_pkg::ST_DRAIN:  state_in = pket_pkg::ST_UPDATE;
         pket_pkg::ST_UPDATE: state_in = pket_pkg::ST_RESP;
         pket_pkg::ST_RESP: begin
            if (sts.rsp_free) begin
               state_in = pket_pkg::ST_IDLE;
            end
         end
         default: state_in = pket_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         pket_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            cmd.load  = req_valid;
         end
         pket_pkg::ST_SCAN:   cmd.scan = 1'b1;
         pket_pkg::ST_DRAIN:  cmd = '0;
         pket_pkg::ST_UPDATE: cmd.commit = 1'b1;
         pket_pkg::ST_RESP:   cmd.respond = sts.rsp_free;
         default:             cmd = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= pket_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

[rtl/pket_dp.sv]
// ----------------------------------------------------------------------------
// pket_dp
// Datapath: config registers, key/time table, scan accumulators, response.
// ----------------------------------------------------------------------------
module pket_dp #(
   parameter int SLOTS    = pket_pkg::SLOTS_DEF,
   parameter int KEY_BITS = pket_pkg::KEY_BITS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_we,
   input  logic [pket_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [pket_pkg::CSR_DATA_W-1:0]     csr_wdata,
   input  logic [pket_pkg::KEY_W-1:0]          key_id,
   input  logic [pket_pkg::KIND_W-1:0]         event_kind,
   input  logic                                force_req,
   input  logic [pket_pkg::TIME_W-1:0]         now_seconds,
   input  pket_pkg::pket_cmd_type              cmd,
   output pket_pkg::pket_sts_type              sts,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic                                rsp_emit,
   output logic [pket_pkg::KIND_W-1:0]         rsp_kind,
   output logic [pket_pkg::KEY_W-1:0]          rsp_key
);

   localparam int IDX_W  = $clog2(SLOTS);
   localparam int CNT_W  = $clog2(SLOTS + 1);
   localparam int CMP_W  = (CNT_W > pket_pkg::LIMIT_W) ? CNT_W : pket_pkg::LIMIT_W;
   localparam int TIME_W = pket_pkg::TIME_W;
   localparam int RAM_W  = KEY_BITS + TIME_W;

   logic [pket_pkg::THR_W-1:0]   throttle_ff, throttle_in;
   logic [pket_pkg::LIMIT_W-1:0] limit_ff, limit_in;

   logic [pket_pkg::KEY_W-1:0]   key_ff, key_in;
   logic [pket_pkg::KIND_W-1:0]  kind_ff, kind_in;
   logic                         force_ff, force_in;
   logic [TIME_W-1:0]            now_ff, now_in;

   logic [IDX_W-1:0]             addr_ff, addr_in;
   logic                         cmp_en_ff, cmp_en_in;
   logic [IDX_W-1:0]             cmp_idx_ff, cmp_idx_in;

   logic                         found_ff, found_in;
   logic [IDX_W-1:0]             found_idx_ff, found_idx_in;
   logic [TIME_W-1:0]            found_time_ff, found_time_in;
   logic                         vict_ff, vict_in;
   logic [IDX_W-1:0]             vict_idx_ff, vict_idx_in;
   logic [TIME_W-1:0]            oldest_ff, oldest_in;
   logic                         free_ff, free_in;
   logic [IDX_W-1:0]             free_idx_ff, free_idx_in;

   logic [SLOTS-1:0]             valid_ff, valid_in;
   logic [CNT_W-1:0]             count_ff, count_in;

   logic                         rsp_valid_ff, rsp_valid_in;
   logic                         rsp_emit_ff, rsp_emit_in;
   logic [pket_pkg::KIND_W-1:0]  rsp_kind_ff, rsp_kind_in;
   logic [pket_pkg::KEY_W-1:0]   rsp_key_ff, rsp_key_in;

   logic [KEY_BITS-1:0]          qkey;
   logic [RAM_W-1:0]             rd_data;
   logic [KEY_BITS-1:0]          rd_key;
   logic [TIME_W-1:0]            rd_time;
   logic                         rd_valid;
   logic [TIME_W:0]              thr_sum;
   logic                         throttled;
   logic                         pass_rec;
   logic                         cnt_full;
   logic                         do_evict;
   logic                         have_slot;
   logic                         do_new;
   logic [IDX_W-1:0]             new_idx;
   logic                         wr_en;
   logic [IDX_W-1:0]             wr_addr;
   logic                         emit_c;

   assign qkey     = KEY_BITS'(key_ff);
   assign rd_key   = rd_data[TIME_W +: KEY_BITS];
   assign rd_time  = rd_data[TIME_W-1:0];
   assign rd_valid = valid_ff[cmp_idx_ff];

   assign thr_sum   = {1'b0, found_time_ff} + (TIME_W + 1)'(throttle_ff);
   assign throttled = found_ff && (thr_sum >= {1'b0, now_ff});
   assign pass_rec  = (kind_ff == pket_pkg::KIND_CHANGED) && !force_ff && !throttled;
   assign cnt_full  = CMP_W'(count_ff) >= CMP_W'(limit_ff);
   assign do_evict  = cmd.commit && pass_rec && cnt_full && vict_ff;
   assign have_slot = free_ff || do_evict;
   assign new_idx   = (do_evict && (!free_ff || (vict_idx_ff < free_idx_ff))) ?
                      vict_idx_ff : free_idx_ff;
   assign do_new    = cmd.commit && pass_rec && !found_ff && have_slot;
   assign wr_en     = (cmd.commit && pass_rec && found_ff) || do_new;
   assign wr_addr   = found_ff ? found_idx_ff : new_idx;

   always_comb begin
      case (kind_ff)
         pket_pkg::KIND_CHANGED: emit_c = force_ff ? found_ff : !throttled;
         pket_pkg::KIND_CREATED: emit_c = 1'b1;
         pket_pkg::KIND_DELETED: emit_c = 1'b1;
         default:                emit_c = 1'b0;
      endcase
   end

   pket_ram #(
      .WIDTH (RAM_W),
      .DEPTH (SLOTS)
   ) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data ({qkey, now_ff}),
      .rd_en   (cmd.scan),
      .rd_addr (addr_ff),
      .rd_data (rd_data)
   );

   // config
   always_comb begin
      throttle_in = throttle_ff;
      limit_in    = limit_ff;
      if (csr_we) begin
         case (csr_index)
            pket_pkg::CSR_THROTTLE: throttle_in = csr_wdata[pket_pkg::THR_W-1:0];
            pket_pkg::CSR_LIMIT:    limit_in    = csr_wdata[pket_pkg::LIMIT_W-1:0];
            default:                limit_in    = limit_ff;
         endcase
      end
   end

   // request capture, scan and accumulators
   always_comb begin
      key_in        = key_ff;
      kind_in       = kind_ff;
      force_in      = force_ff;
      now_in        = now_ff;
      addr_in       = addr_ff;
      cmp_en_in     = cmd.scan;
      cmp_idx_in    = addr_ff;
      found_in      = found_ff;
      found_idx_in  = found_idx_ff;
      found_time_in = found_time_ff;
      vict_in       = vict_ff;
      vict_idx_in   = vict_idx_ff;
      oldest_in     = oldest_ff;
      free_in       = free_ff;
      free_idx_in   = free_idx_ff;
      if (cmd.load) begin
         key_in    = key_id;
         kind_in   = event_kind;
         force_in  = force_req;
         now_in    = now_seconds;
         addr_in   = '0;
         found_in  = 1'b0;
         vict_in   = 1'b0;
         free_in   = 1'b0;
         oldest_in = now_seconds;
      end
      if (cmd.scan) begin
         addr_in = addr_ff + IDX_W'(1);
      end
      if (cmp_en_ff) begin
         if (rd_valid && (rd_key == qkey)) begin
            found_in      = 1'b1;
            found_idx_in  = cmp_idx_ff;
            found_time_in = rd_time;
         end
         if (rd_valid && (rd_time <= oldest_ff) && (rd_key != qkey)) begin
            vict_in     = 1'b1;
            vict_idx_in = cmp_idx_ff;
            oldest_in   = rd_time;
         end
         if (!rd_valid && !free_ff) begin
            free_in     = 1'b1;
            free_idx_in = cmp_idx_ff;
         end
      end
   end

   // table occupancy
   always_comb begin
      valid_in = valid_ff;
      if (do_evict) begin
         valid_in[vict_idx_ff] = 1'b0;
      end
      if (do_new) begin
         valid_in[new_idx] = 1'b1;
      end
      count_in = count_ff - CNT_W'(do_evict) + CNT_W'(do_new);
   end

   // response register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_emit_in  = rsp_emit_ff;
      rsp_kind_in  = rsp_kind_ff;
      rsp_key_in   = rsp_key_ff;
      if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (cmd.respond) begin
         rsp_valid_in = 1'b1;
         rsp_emit_in  = emit_c;
         rsp_kind_in  = kind_ff;
         rsp_key_in   = key_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         throttle_ff  <= pket_pkg::THROTTLE_RESET;
         limit_ff     <= pket_pkg::LIMIT_RESET;
         valid_ff     <= '0;
         count_ff     <= '0;
         cmp_en_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         throttle_ff  <= throttle_in;
         limit_ff     <= limit_in;
         valid_ff     <= valid_in;
         count_ff     <= count_in;
         cmp_en_ff    <= cmp_en_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      key_ff        <= key_in;
      kind_ff       <= kind_in;
      force_ff      <= force_in;
      now_ff        <= now_in;
      addr_ff       <= addr_in;
      cmp_idx_ff    <= cmp_idx_in;
      found_ff      <= found_in;
      found_idx_ff  <= found_idx_in;
      found_time_ff <= found_time_in;
      vict_ff       <= vict_in;
      vict_idx_ff   <= vict_idx_in;
      oldest_ff     <= oldest_in;
      free_ff       <= free_in;
      free_idx_ff   <= free_idx_in;
      rsp_emit_ff   <= rsp_emit_in;
      rsp_kind_ff   <= rsp_kind_in;
      rsp_key_ff    <= rsp_key_in;
   end

   assign sts.in_changed = (event_kind == pket_pkg::KIND_CHANGED);
   assign sts.scan_last  = (addr_ff == IDX_W'(SLOTS - 1));
   assign sts.rsp_free   = !rsp_valid_ff || rsp_ready;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_emit  = rsp_emit_ff;
   assign rsp_kind  = rsp_kind_ff;
   assign rsp_key   = rsp_key_ff;

endmodule

[rtl/per_key_event_throttle_top.sv]
// ----------------------------------------------------------------------------
// per_key_event_throttle_top
// Per-key rate limiter for notification events with oldest-entry eviction.
// ----------------------------------------------------------------------------
// One response per request. Created, deleted and unknown-kind events go from
// the idle state straight to the response state; changed events first scan the
// key/time table one slot per cycle through its single read port, then pass
// through the drain and update states. A new request is taken while the
// previous response still waits in the output register. Write the CSRs only
// while idle.
module per_key_event_throttle_top #(
   parameter int SLOTS    = pket_pkg::SLOTS_DEF,
   parameter int KEY_BITS = pket_pkg::KEY_BITS_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   pket_req_if.sink                        req_chan,
   pket_rsp_if.source                      rsp_chan,
   input  logic                            csr_we,
   input  logic [pket_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [pket_pkg::CSR_DATA_W-1:0] csr_wdata
);

   pket_pkg::pket_cmd_type cmd;
   pket_pkg::pket_sts_type sts;
   logic                   req_ready;

   pket_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   pket_dp #(
      .SLOTS    (SLOTS),
      .KEY_BITS (KEY_BITS)
   ) u_dp (
      .clock       (clock),
      .reset       (reset),
      .csr_we      (csr_we),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .key_id      (req_chan.key_id),
      .event_kind  (req_chan.event_kind),
      .force_req   (req_chan.force_req),
      .now_seconds (req_chan.now_seconds),
      .cmd         (cmd),
      .sts         (sts),
      .rsp_valid   (rsp_chan.valid),
      .rsp_ready   (rsp_chan.ready),
      .rsp_emit    (rsp_chan.emit),
      .rsp_kind    (rsp_chan.signal_kind),
      .rsp_key     (rsp_chan.out_key)
   );

   assign req_chan.ready = req_ready;

endmodule
